FILE: rtl/cap_pkg.sv
// Shared types, kind codes and the element type map for the civic address parser.
// No dependencies; every other file but cap_if imports this package.
`timescale 1ns / 1ps
`default_nettype none
package cap_pkg;

	localparam int unsigned CAP_QUEUE_DEPTH = 4;

	localparam logic [1:0] KIND_COUNTRY = 2'd0;
	localparam logic [1:0] KIND_OPEN    = 2'd1;
	localparam logic [1:0] KIND_CHAR    = 2'd2;
	localparam logic [1:0] KIND_CLOSE   = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] element_code;
		logic [7:0] out_char;
		logic       truncated;
		logic       last_of_run;
	} cap_res_t;

	// Results of one byte: count 0..2, slot r0 first.
	typedef struct packed {
		logic [1:0] count;
		cap_res_t   r0;
		cap_res_t   r1;
	} cap_step_t;

	typedef struct packed {
		logic       known;
		logic [4:0] code;
	} cap_map_t;

	// Map a raw element type to its dense code.
	function automatic cap_map_t cap_map_type(input logic [7:0] t);
		cap_map_t m;
		m.known = 1'b0;
		m.code  = 5'd0;
		if (t >= 8'd1 && t <= 8'd6) begin
			m.known = 1'b1;
			m.code  = 5'(t - 8'd1);
		end else if (t >= 8'd16 && t <= 8'd24) begin
			m.known = 1'b1;
			m.code  = 5'(t - 8'd10);
		end else if (t == 8'd27) begin
			m.known = 1'b1;
			m.code  = 5'd15;
		end else if (t == 8'd33) begin
			m.known = 1'b1;
			m.code  = 5'd16;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/cap_if.sv
// Channel interfaces for the civic address parser: option bytes in, results out.
// Does not depend on cap_pkg; the field widths are written out here.
`timescale 1ns / 1ps
`default_nettype none
interface cap_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_option;

	modport source(output valid, output data_byte, output end_of_option, input ready);
	modport sink(input valid, input data_byte, input end_of_option, output ready);
endinterface

interface cap_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [4:0] element_code;
	logic [7:0] out_char;
	logic       truncated;
	logic       last_of_run;

	modport source(output valid, output kind, output element_code, output out_char,
		output truncated, output last_of_run, input ready);
	modport sink(input valid, input kind, input element_code, input out_char,
		input truncated, input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: rtl/cap_step.sv
// Parser state registers and the per-byte next-state and result logic.
// Depends on cap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cap_step (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        data_byte,
	input  wire logic              end_of_option,
	output cap_pkg::cap_step_t     step
);
	import cap_pkg::*;

	localparam logic [2:0] PH_WHAT  = 3'd0;
	localparam logic [2:0] PH_CC1   = 3'd1;
	localparam logic [2:0] PH_CC2   = 3'd2;
	localparam logic [2:0] PH_TYPE  = 3'd3;
	localparam logic [2:0] PH_LEN   = 3'd4;
	localparam logic [2:0] PH_VALUE = 3'd5;

	logic [2:0] phase_q, phase_n;
	logic [4:0] elem_q, elem_n;
	logic       known_q, known_n;
	logic [7:0] remain_q, remain_n;

	cap_res_t   slot [2];
	logic [1:0] cnt;
	logic       open_n;
	logic [7:0] rem_dec;
	cap_map_t   m;

	always_comb begin
		phase_n  = phase_q;
		elem_n   = elem_q;
		known_n  = known_q;
		remain_n = remain_q;
		open_n   = 1'b0;
		cnt      = 2'd0;
		slot[0]  = '0;
		slot[1]  = '0;
		m        = cap_map_type(data_byte);
		rem_dec  = remain_q - 8'd1;
		case (phase_q)
			PH_CC1, PH_CC2: begin
				slot[0].kind     = KIND_COUNTRY;
				slot[0].out_char = data_byte;
				cnt              = 2'd1;
				phase_n          = (phase_q == PH_CC1) ? PH_CC2 : PH_TYPE;
			end
			PH_TYPE: begin
				elem_n  = m.known ? m.code : 5'd0;
				known_n = m.known;
				if (m.known) begin
					slot[0].kind         = KIND_OPEN;
					slot[0].element_code = m.code;
					cnt                  = 2'd1;
					open_n               = 1'b1;
				end
				phase_n = PH_LEN;
			end
			PH_LEN: begin
				remain_n = data_byte;
				if (data_byte == 8'd0) begin
					if (known_q) begin
						slot[0].kind         = KIND_CLOSE;
						slot[0].element_code = elem_q;
						cnt                  = 2'd1;
					end
					phase_n = PH_TYPE;
				end else begin
					open_n  = known_q;
					phase_n = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (known_q && data_byte > 8'h1f && data_byte < 8'h7f) begin
					slot[0].kind         = KIND_CHAR;
					slot[0].element_code = elem_q;
					slot[0].out_char     = data_byte;
					cnt                  = 2'd1;
				end
				remain_n = rem_dec;
				if (rem_dec == 8'd0) begin
					if (known_q) begin
						slot[cnt[0]].kind         = KIND_CLOSE;
						slot[cnt[0]].element_code = elem_q;
						cnt                       = cnt + 2'd1;
					end
					phase_n = PH_TYPE;
				end else begin
					open_n = known_q;
				end
			end
			default: begin
				phase_n = PH_CC1;
			end
		endcase
		// Option end: close an unfinished element as truncated, then reset.
		if (end_of_option) begin
			if (open_n) begin
				slot[cnt[0]].kind         = KIND_CLOSE;
				slot[cnt[0]].element_code = elem_n;
				slot[cnt[0]].truncated    = 1'b1;
				cnt                       = cnt + 2'd1;
			end
			phase_n  = PH_WHAT;
			elem_n   = 5'd0;
			known_n  = 1'b0;
			remain_n = 8'd0;
		end
		if (cnt == 2'd1) begin
			slot[0].last_of_run = 1'b1;
		end else if (cnt == 2'd2) begin
			slot[1].last_of_run = 1'b1;
		end
		step.count = cnt;
		step.r0    = slot[0];
		step.r1    = slot[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WHAT;
			elem_q   <= 5'd0;
			known_q  <= 1'b0;
			remain_q <= 8'd0;
		end else if (accept) begin
			phase_q  <= phase_n;
			elem_q   <= elem_n;
			known_q  <= known_n;
			remain_q <= remain_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/cap_queue.sv
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on cap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cap_queue #(
	parameter int unsigned DEPTH = cap_pkg::CAP_QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        push_count,
	input  wire cap_pkg::cap_res_t push_r0,
	input  wire cap_pkg::cap_res_t push_r1,
	output logic                   room,
	output logic                   head_valid,
	output cap_pkg::cap_res_t      head,
	input  wire logic              pop
);
	import cap_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cap_res_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q, wr_next, wr_two, rd_next;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign wr_next    = wrap_inc(wr_q);
	assign wr_two     = wrap_inc(wr_next);
	assign rd_next    = wrap_inc(rd_q);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];
	assign do_pop     = pop && head_valid;
	// Keep space for the worst case of two results from one byte.
	assign room       = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_q] <= push_r0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_next] <= push_r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push_count == 2'd1) begin
				wr_q <= wr_next;
			end else if (push_count == 2'd2) begin
				wr_q <= wr_two;
			end
			if (do_pop) begin
				rd_q <= rd_next;
			end
			count_q <= count_q + CW'(push_count) - CW'(do_pop);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/civic_address_tlv_parser.sv
// Top level of the civic address option parser: step logic plus result queue.
// Depends on cap_pkg, cap_if (cap_byte_if, cap_result_if), cap_step, cap_queue.
//
//  channel  | role   | payload                                             | per transaction
//  ---------+--------+-----------------------------------------------------+----------------
//  option   | sink   | data_byte, end_of_option                            | one option byte
//  result   | source | kind, element_code, out_char, truncated, last_of_run| one result
//
// A byte is taken in the cycle it is offered whenever the queue has room for two
// results; they enter the queue at that edge and, if it was empty, the first one is
// visible on the result channel in the next cycle. One byte per cycle is sustained
// while result.ready is high and bytes yield at most one result each; a byte with two
// results costs the result side two transactions, so the queue depth (QUEUE_DEPTH)
// sets how long a stalled result side is absorbed; reset clears parse state and queue.
`timescale 1ns / 1ps
`default_nettype none
module civic_address_tlv_parser #(
	parameter int unsigned QUEUE_DEPTH = cap_pkg::CAP_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	cap_byte_if.sink        option,
	cap_result_if.source    result
);
	import cap_pkg::*;

	cap_step_t step;
	cap_res_t  head;
	logic      room;
	logic      head_valid;
	logic      accept;

	// A transaction on the option channel advances the parser.
	assign option.ready = room;
	assign accept       = option.valid && room;

	cap_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (option.data_byte),
		.end_of_option (option.end_of_option),
		.step          (step)
	);

	// Push nothing unless the byte is actually taken.
	cap_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (accept ? step.count : 2'd0),
		.push_r0    (step.r0),
		.push_r1    (step.r1),
		.room       (room),
		.head_valid (head_valid),
		.head       (head),
		.pop        (result.ready)
	);

	assign result.valid        = head_valid;
	assign result.kind         = head.kind;
	assign result.element_code = head.element_code;
	assign result.out_char     = head.out_char;
	assign result.truncated    = head.truncated;
	assign result.last_of_run  = head.last_of_run;

endmodule
`default_nettype wire

FILE: dv/tb_civic_address_tlv_parser.sv
// Testbench for civic_address_tlv_parser: option bytes in, typed results out, checked in order.
// Needs cap_pkg, cap_if (cap_byte_if, cap_result_if) and the parser RTL; reads no files.
`timescale 1ns / 1ps
module tb_civic_address_tlv_parser;
	import cap_pkg::*;

	// Parse phases of the byte-serial option walk.
	typedef enum logic [2:0] {
		PH_WHAT  = 3'd0,
		PH_CC1   = 3'd1,
		PH_CC2   = 3'd2,
		PH_TYPE  = 3'd3,
		PH_LEN   = 3'd4,
		PH_VALUE = 3'd5
	} parse_phase_e;

	logic clk = 1'b0;
	logic arst_n;

	cap_byte_if   option_ch ();
	cap_result_if result_ch ();

	civic_address_tlv_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.option (option_ch),
		.result (result_ch)
	);

	// Shadow parse state, advanced once per accepted option byte.
	parse_phase_e pred_phase;
	logic [4:0]   pred_code;
	logic         pred_known;
	logic [7:0]   pred_remaining;

	cap_res_t     pending_results[$];   // results owed by the block, oldest first
	logic [8:0]   option_bytes[$];      // {end_of_option, data_byte} of the option to send

	int           error_count = 0;
	int           snd_idle_pct = 0;
	int           rcv_idle_pct = 0;
	int           hold_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block wedges or loses a result.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Return {known, dense code} for a raw element type.
	function automatic logic [5:0] dense_code_of(input logic [7:0] t);
		if (t >= 8'd1 && t <= 8'd6)
			return {1'b1, 5'(t - 8'd1)};
		if (t >= 8'd16 && t <= 8'd24)
			return {1'b1, 5'(t - 8'd10)};
		if (t == 8'd27)
			return {1'b1, 5'd15};
		if (t == 8'd33)
			return {1'b1, 5'd16};
		return 6'd0;
	endfunction

	function automatic cap_res_t make_result(input logic [1:0] kind, input logic [4:0] code,
			input logic [7:0] ch, input logic trunc);
		cap_res_t r;
		r.kind         = kind;
		r.element_code = code;
		r.out_char     = ch;
		r.truncated    = trunc;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	function automatic void clear_parse_state();
		pred_phase     = PH_WHAT;
		pred_code      = 5'd0;
		pred_known     = 1'b0;
		pred_remaining = 8'd0;
	endfunction

	// Advance the shadow parser by one byte and queue the results it owes.
	function automatic void predict_byte(input logic [7:0] b, input logic eoo);
		cap_res_t   r[2];
		int         n;
		logic       still_open;
		logic [5:0] m;
		n          = 0;
		still_open = 1'b0;
		case (pred_phase)
			PH_CC1: begin
				r[n] = make_result(KIND_COUNTRY, 5'd0, b, 1'b0);
				n++;
				pred_phase = PH_CC2;
			end
			PH_CC2: begin
				r[n] = make_result(KIND_COUNTRY, 5'd0, b, 1'b0);
				n++;
				pred_phase = PH_TYPE;
			end
			PH_TYPE: begin
				m = dense_code_of(b);
				if (m[5]) begin
					pred_code  = m[4:0];
					pred_known = 1'b1;
					r[n] = make_result(KIND_OPEN, pred_code, 8'd0, 1'b0);
					n++;
					still_open = 1'b1;
				end else begin
					pred_code  = 5'd0;
					pred_known = 1'b0;
				end
				pred_phase = PH_LEN;
			end
			PH_LEN: begin
				pred_remaining = b;
				if (b == 8'd0) begin
					// Empty value: close right away, unknown types just move on.
					if (pred_known) begin
						r[n] = make_result(KIND_CLOSE, pred_code, 8'd0, 1'b0);
						n++;
					end
					pred_phase = PH_TYPE;
				end else begin
					still_open = pred_known;
					pred_phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				// Keep printable bytes only; every byte still counts against the length.
				if (pred_known && b >= 8'h20 && b <= 8'h7E) begin
					r[n] = make_result(KIND_CHAR, pred_code, b, 1'b0);
					n++;
				end
				pred_remaining = pred_remaining - 8'd1;
				if (pred_remaining == 8'd0) begin
					if (pred_known) begin
						r[n] = make_result(KIND_CLOSE, pred_code, 8'd0, 1'b0);
						n++;
					end
					pred_phase = PH_TYPE;
				end else begin
					still_open = pred_known;
				end
			end
			default: pred_phase = PH_CC1;
		endcase
		if (eoo) begin
			// Option ended with an element still open: force a truncated close.
			if (still_open) begin
				r[n] = make_result(KIND_CLOSE, pred_code, 8'd0, 1'b1);
				n++;
			end
			clear_parse_state();
		end
		if (n > 0)
			r[n - 1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			pending_results.push_back(r[i]);
	endfunction

	// Count down a long hold-off of the result side on every clock edge.
	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
	end

	// Result side: check each transaction against the oldest pending result, then
	// pick ready for the next edge (held low while a hold-off is counting down).
	always @(posedge clk) begin
		cap_res_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: unexpected result kind=%0d code=%0d char=%02h trunc=%0b last=%0b",
						$realtime, result_ch.kind, result_ch.element_code, result_ch.out_char,
						result_ch.truncated, result_ch.last_of_run);
			end else begin
				want = pending_results.pop_front();
				if (result_ch.kind !== want.kind || result_ch.element_code !== want.element_code
						|| result_ch.out_char !== want.out_char
						|| result_ch.truncated !== want.truncated
						|| result_ch.last_of_run !== want.last_of_run) begin
					error_count++;
					if (error_count <= 10) begin
						$display("%0t: mismatch, expected kind=%0d code=%0d char=%02h trunc=%0b last=%0b",
							$realtime, want.kind, want.element_code, want.out_char,
							want.truncated, want.last_of_run);
						$display("    got kind=%0d code=%0d char=%02h trunc=%0b last=%0b",
							result_ch.kind, result_ch.element_code, result_ch.out_char,
							result_ch.truncated, result_ch.last_of_run);
					end
				end
			end
		end
		if (hold_cycles > 0) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	// Offer one byte, idling first at the current sender rate, and hold it until taken.
	// Valid stays high between back-to-back bytes so it is never dropped and raised in one step.
	task automatic send_byte(input logic [7:0] b, input logic eoo);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < snd_idle_pct)
			gap++;
		if (gap > 0) begin
			option_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		option_ch.valid         <= 1'b1;
		option_ch.data_byte     <= b;
		option_ch.end_of_option <= eoo;
		do
			@(posedge clk);
		while (!option_ch.ready);
		predict_byte(b, eoo);
	endtask

	task automatic send_option_bytes(inout int sent);
		while (option_bytes.size() > 0) begin
			logic [8:0] x;
			x = option_bytes.pop_front();
			send_byte(x[7:0], x[8]);
			sent++;
		end
	endtask

	// Drop valid and wait for every owed result, then let the pipe settle.
	task automatic wait_drained();
		option_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_known_type();
		int r;
		r = $urandom_range(0, 16);
		if (r < 6)
			return 8'(r + 1);
		if (r < 15)
			return 8'(r + 10);
		if (r == 15)
			return 8'd27;
		return 8'd33;
	endfunction

	function automatic void mark_last_byte();
		logic [8:0] x;
		x = option_bytes.pop_back();
		x[8] = 1'b1;
		option_bytes.push_back(x);
	endfunction

	// Build one random option: mostly well-formed element runs with random content,
	// some cut short at a random byte, and a few of pure noise.
	function automatic void build_random_option();
		int n_el;
		int len;
		int cut;
		int r;
		option_bytes.delete();
		if ($urandom_range(0, 9) == 0) begin
			n_el = $urandom_range(1, 12);
			for (int i = 0; i < n_el; i++)
				option_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
		end else begin
			option_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
			for (int i = 0; i < 2; i++)
				if ($urandom_range(0, 9) == 0)
					option_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
				else
					option_bytes.push_back({1'b0, 8'($urandom_range(65, 90))});
			n_el = $urandom_range(0, 5);
			for (int e = 0; e < n_el; e++) begin
				if ($urandom_range(0, 9) < 7)
					option_bytes.push_back({1'b0, pick_known_type()});
				else
					option_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
				r = $urandom_range(0, 99);
				if (r < 75)
					len = $urandom_range(0, 6);
				else if (r < 95)
					len = $urandom_range(7, 20);
				else
					len = $urandom_range(0, 255);
				option_bytes.push_back({1'b0, 8'(len)});
				for (int v = 0; v < len; v++)
					if ($urandom_range(0, 3) != 0)
						option_bytes.push_back({1'b0, 8'($urandom_range(32, 126))});
					else
						option_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
			end
			// Cut some options short, and every long one, to hit truncation anywhere.
			if ($urandom_range(0, 4) == 0 || option_bytes.size() > 48) begin
				cut = $urandom_range(1, (option_bytes.size() > 48) ? 48 : option_bytes.size());
				while (option_bytes.size() > cut)
					void'(option_bytes.pop_back());
			end
		end
		mark_last_byte();
	endfunction

	// Directed options: field extremes, every result kind and the corner cases of the parse.
	task automatic test_directed_options();
		int sent;
		sent = 0;
		option_bytes.delete();
		// what 0xFF, country chars at both byte extremes
		option_bytes.push_back({1'b0, 8'hFF});
		option_bytes.push_back({1'b0, 8'h00});
		option_bytes.push_back({1'b0, 8'hFF});
		// A1 with the printable boundaries 0x20 and 0x7E
		option_bytes.push_back({1'b0, 8'h01});
		option_bytes.push_back({1'b0, 8'h02});
		option_bytes.push_back({1'b0, 8'h20});
		option_bytes.push_back({1'b0, 8'h7E});
		// SEAT with zero length: open and plain close
		option_bytes.push_back({1'b0, 8'h21});
		option_bytes.push_back({1'b0, 8'h00});
		// unknown type 0 with zero length: nothing at all
		option_bytes.push_back({1'b0, 8'h00});
		option_bytes.push_back({1'b0, 8'h00});
		// unknown type 0xFF: value skipped silently
		option_bytes.push_back({1'b0, 8'hFF});
		option_bytes.push_back({1'b0, 8'h01});
		option_bytes.push_back({1'b0, 8'h41});
		// FLR with only non-printable bytes: open then close, no chars
		option_bytes.push_back({1'b0, 8'h1B});
		option_bytes.push_back({1'b0, 8'h03});
		option_bytes.push_back({1'b0, 8'h1F});
		option_bytes.push_back({1'b0, 8'h7F});
		option_bytes.push_back({1'b0, 8'h80});
		// PC as the final byte: open plus truncated close
		option_bytes.push_back({1'b1, 8'h18});
		// option ending inside the country code
		option_bytes.push_back({1'b0, 8'h00});
		option_bytes.push_back({1'b1, 8'h43});
		// A6 ending on its length byte: truncated close
		option_bytes.push_back({1'b0, 8'h00});
		option_bytes.push_back({1'b0, 8'h44});
		option_bytes.push_back({1'b0, 8'h45});
		option_bytes.push_back({1'b0, 8'h06});
		option_bytes.push_back({1'b1, 8'h05});
		send_option_bytes(sent);
	endtask

	task automatic test_random_options(input int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			build_random_option();
			send_option_bytes(sent);
		end
	endtask

	// Stall the result side for a long stretch while a long PRD value streams in,
	// so the result queue fills and the option side must back off.
	task automatic test_receiver_hold();
		int sent;
		sent = 0;
		option_bytes.delete();
		option_bytes.push_back({1'b0, 8'h00});
		option_bytes.push_back({1'b0, 8'h46});
		option_bytes.push_back({1'b0, 8'h49});
		option_bytes.push_back({1'b0, 8'h10});
		option_bytes.push_back({1'b0, 8'd40});
		for (int v = 0; v < 40; v++)
			option_bytes.push_back({1'b0, 8'($urandom_range(32, 126))});
		mark_last_byte();
		hold_cycles = 120;
		send_option_bytes(sent);
	endtask

	initial begin
		arst_n                  = 1'b0;
		option_ch.valid         = 1'b0;
		option_ch.data_byte     = 8'd0;
		option_ch.end_of_option = 1'b0;
		result_ch.ready         = 1'b0;
		clear_parse_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 32;
		rcv_idle_pct = 54;
		test_directed_options();
		test_random_options(370);
		wait_drained();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_receiver_hold();
		wait_drained();

		snd_idle_pct = 54;
		rcv_idle_pct = 32;
		test_random_options(370);
		wait_drained();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random_options(360);
		wait_drained();

		if (error_count == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: sim.f
rtl/cap_pkg.sv
rtl/cap_if.sv
rtl/cap_step.sv
rtl/cap_queue.sv
rtl/civic_address_tlv_parser.sv
dv/tb_civic_address_tlv_parser.sv
